@@ sv/stnt_pkg.sv @@
// ----------------------------------------------------------------------------
// stnt_pkg
// Shared types, constants and helpers for the sorted top-N score table.
// ----------------------------------------------------------------------------
`default_nettype none

package stnt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CW          = AW + 1;

  localparam int ACT_W = 2;
  localparam int IDX_W = 4;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;

  localparam logic [POS_W-1:0] NO_POS    = POS_W'(16);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0]    LAST_PASS = AW'(TABLE_DEPTH - 2);

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SORT   = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_READ   = 2'd3
  } act_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        insert_position;
    logic                    inserted;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;
  } ram_req_t;

  function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
    logic [IDX_W+AW-1:0] ext;
    ext = {{AW{1'b0}}, idx};
    return ext < (IDX_W + AW)'(TABLE_DEPTH);
  endfunction

  function automatic logic [AW-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W+AW-1:0] ext;
    ext = {{AW{1'b0}}, idx};
    return ext[AW-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_to_out(input logic [AW-1:0] p);
    logic [POS_W+AW-1:0] ext;
    ext = {{POS_W{1'b0}}, p};
    return ext[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/stnt_if.sv @@
// ----------------------------------------------------------------------------
// stnt_if
// Valid/ready channels for action requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface stnt_in_if import stnt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, action, index, value, input ready);
  modport sink   (input valid, action, index, value, output ready);
endinterface

interface stnt_out_if import stnt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [POS_W-1:0]        insert_position;
  logic                    inserted;

  modport source (output valid, read_value, insert_position, inserted, input ready);
  modport sink   (input valid, read_value, insert_position, inserted, output ready);
endinterface

`default_nettype wire

@@ sv/sorted_top_n_table.sv @@
// ----------------------------------------------------------------------------
// sorted_top_n_table
// Descending score table in RAM with load, sort, insert and read actions.
// ----------------------------------------------------------------------------
// One action in flight; the next is taken in the cycle after the result moves
// to the output register, while that result may still wait there. Insert and
// sort are bound by the single RAM read port, one entry a cycle outside the
// swap writes between sort passes. Reset clears per-entry valid flags, so the
// table reads as zero at once.
`default_nettype none

module sorted_top_n_table import stnt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stnt_in_if.sink   in_i,
  stnt_out_if.source out_o
);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  ram_req_t         ram_req;
  logic [VAL_W-1:0] ram_rdata;
  logic             out_valid_q;
  res_t             out_q;

  stnt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  stnt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.read_value      = out_q.read_value;
  assign out_o.insert_position = out_q.insert_position;
  assign out_o.inserted        = out_q.inserted;

endmodule

`default_nettype wire

@@ sv/stnt_ram.sv @@
// ----------------------------------------------------------------------------
// stnt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stnt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/stnt_ctrl.sv @@
// ----------------------------------------------------------------------------
// stnt_ctrl
// Action sequencer: single-entry load and read; read-modify-write walks over
// the RAM for ripple insert and selection sort. Valid flags give reset zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module stnt_ctrl import stnt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  stnt_in_if.sink               in_i,
  output logic                  res_valid_o,
  output res_t                  res_o,
  input  wire logic             res_ready_i,
  output ram_req_t              ram_o,
  input  wire logic [VAL_W-1:0] ram_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_INS,
    ST_SORT,
    ST_SW1,
    ST_SW2,
    ST_DONE
  } state_e;

  localparam res_t RES_NONE = '{read_value: '0, insert_position: NO_POS, inserted: 1'b0};

  state_e                  state_q, state_d;
  logic [CW-1:0]           r_q, r_d;
  logic                    pv_q, pv_d;
  logic [AW-1:0]           pa_q, pa_d;
  logic                    rok_q, rok_d;
  logic signed [VAL_W-1:0] s_q, s_d;
  logic                    found_q, found_d;
  logic signed [VAL_W-1:0] carry_q, carry_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic [AW-1:0]           i_q, i_d;
  logic signed [VAL_W-1:0] best_q, best_d;
  logic [AW-1:0]           bidx_q, bidx_d;
  logic signed [VAL_W-1:0] oldi_q, oldi_d;
  logic [TABLE_DEPTH-1:0]  vld_q, vld_d;
  res_t                    res_q, res_d;
  logic signed [VAL_W-1:0] entry;

  assign entry       = vld_q[pa_q] ? $signed(ram_rdata_i) : '0;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    pv_d    = pv_q;
    pa_d    = pa_q;
    rok_d   = rok_q;
    s_d     = s_q;
    found_d = found_q;
    carry_d = carry_q;
    pos_d   = pos_q;
    i_d     = i_q;
    best_d  = best_q;
    bidx_d  = bidx_q;
    oldi_d  = oldi_q;
    vld_d   = vld_q;
    res_d   = res_q;
    ram_o.we    = 1'b0;
    ram_o.waddr = pa_q;
    ram_o.wdata = carry_q;
    ram_o.re    = 1'b0;
    ram_o.raddr = r_q[AW-1:0];

    // read issue for the scanning walks
    if ((state_q == ST_INS || state_q == ST_SORT) && r_q < CW'(TABLE_DEPTH)) begin
      ram_o.re = 1'b1;
      pv_d     = 1'b1;
      pa_d     = r_q[AW-1:0];
      r_d      = r_q + CW'(1);
    end else if (state_q == ST_INS || state_q == ST_SORT) begin
      pv_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          res_d = RES_NONE;
          case (act_e'(in_i.action))
            ACT_LOAD: begin
              ram_o.we    = idx_in_range(in_i.index);
              ram_o.waddr = idx_to_addr(in_i.index);
              ram_o.wdata = in_i.value;
              state_d     = ST_DONE;
            end
            ACT_READ: begin
              ram_o.re    = 1'b1;
              ram_o.raddr = idx_to_addr(in_i.index);
              pa_d        = idx_to_addr(in_i.index);
              rok_d       = idx_in_range(in_i.index);
              state_d     = ST_RD;
            end
            ACT_INSERT: begin
              s_d     = in_i.value;
              found_d = 1'b0;
              r_d     = '0;
              pv_d    = 1'b0;
              state_d = ST_INS;
            end
            ACT_SORT: begin
              i_d     = '0;
              r_d     = '0;
              pv_d    = 1'b0;
              state_d = ST_SORT;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_RD: begin
        res_d.read_value = rok_q ? entry : '0;
        state_d          = ST_DONE;
      end
      ST_INS: begin
        if (pv_q) begin
          if (!found_q && s_q > entry) begin
            ram_o.we    = 1'b1;
            ram_o.wdata = s_q;
            carry_d     = entry;
            found_d     = 1'b1;
            pos_d       = pa_q;
          end else if (found_q) begin
            // ripple the displaced entries down one place
            ram_o.we = 1'b1;
            carry_d  = entry;
          end
          if (pa_q == LAST_ADDR) begin
            res_d.inserted        = found_d;
            res_d.insert_position = found_d ? pos_to_out(pos_d) : NO_POS;
            state_d               = ST_DONE;
          end
        end
      end
      ST_SORT: begin
        if (pv_q) begin
          if (pa_q == i_q) begin
            best_d = entry;
            bidx_d = i_q;
            oldi_d = entry;
          end else if (entry > best_q) begin
            best_d = entry;
            bidx_d = pa_q;
          end
          if (pa_q == LAST_ADDR) begin
            state_d = ST_SW1;
          end
        end
      end
      ST_SW1: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = i_q;
        ram_o.wdata = best_q;
        state_d     = ST_SW2;
      end
      ST_SW2: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = bidx_q;
        ram_o.wdata = oldi_q;
        if (i_q == LAST_PASS) begin
          state_d = ST_DONE;
        end else begin
          i_d     = i_q + AW'(1);
          r_d     = CW'(i_q) + CW'(1);
          pv_d    = 1'b0;
          state_d = ST_SORT;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (ram_o.we) begin
      vld_d[ram_o.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      pv_q    <= 1'b0;
      pa_q    <= '0;
      rok_q   <= 1'b0;
      s_q     <= '0;
      found_q <= 1'b0;
      carry_q <= '0;
      pos_q   <= '0;
      i_q     <= '0;
      best_q  <= '0;
      bidx_q  <= '0;
      oldi_q  <= '0;
      vld_q   <= '0;
      res_q   <= RES_NONE;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      pv_q    <= pv_d;
      pa_q    <= pa_d;
      rok_q   <= rok_d;
      s_q     <= s_d;
      found_q <= found_d;
      carry_q <= carry_d;
      pos_q   <= pos_d;
      i_q     <= i_d;
      best_q  <= best_d;
      bidx_q  <= bidx_d;
      oldi_q  <= oldi_d;
      vld_q   <= vld_d;
      res_q   <= res_d;
    end
  end

  a_scan_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (state_q == ST_INS || state_q == ST_SORT))
    else $error("read pending outside a table walk");

  a_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_o.we && ram_o.re) |-> (ram_o.waddr != ram_o.raddr))
    else $error("RAM read and write collide on one entry");

  a_found_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && state_q == ST_INS) |=> found_q)
    else $error("insert position lost mid-walk");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !res_ready_i) |=> (state_q == ST_DONE && $stable(res_q)))
    else $error("result dropped before hand-off");

endmodule

`default_nettype wire

@@ verif/score_table_checker.sv @@
// ----------------------------------------------------------------------------
// score_table_checker
// Watches the request and result channels of the sorted top-N score table.
// Keeps its own copy of the score table, works out the result of every
// accepted request and compares each result transaction, field by field,
// against the oldest result still owed.
// ----------------------------------------------------------------------------
module score_table_checker import stnt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  stnt_in_if   req_mon,
  stnt_out_if  res_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_checked_o,
  output int   scores_placed_o
);

  logic signed [VAL_W-1:0] score_mirror [TABLE_DEPTH];
  res_t                    owed_results [$];
  res_t                    owed;
  res_t                    seen;

  function automatic res_t apply_action(input act_e act, input logic [IDX_W-1:0] idx,
                                        input logic signed [VAL_W-1:0] val);
    res_t                    r;
    int                      i;
    int                      j;
    int                      best;
    int                      pos;
    logic signed [VAL_W-1:0] swap;
    r.read_value      = '0;
    r.insert_position = NO_POS;
    r.inserted        = 1'b0;
    case (act)
      ACT_LOAD: begin
        if (int'(idx) < TABLE_DEPTH) score_mirror[idx] = val;
      end
      ACT_SORT: begin
        for (i = 0; i < TABLE_DEPTH - 1; i++) begin
          best = i;
          for (j = i + 1; j < TABLE_DEPTH; j++)
            if (score_mirror[j] > score_mirror[best]) best = j;
          swap               = score_mirror[i];
          score_mirror[i]    = score_mirror[best];
          score_mirror[best] = swap;
        end
      end
      ACT_INSERT: begin
        pos = -1;
        for (i = 0; i < TABLE_DEPTH && pos < 0; i++)
          if (val > score_mirror[i]) pos = i;
        if (pos >= 0) begin
          for (j = TABLE_DEPTH - 1; j > pos; j--) score_mirror[j] = score_mirror[j-1];
          score_mirror[pos] = val;
          r.insert_position = POS_W'(pos);
          r.inserted        = 1'b1;
        end
      end
      default: begin
        if (int'(idx) < TABLE_DEPTH) r.read_value = score_mirror[idx];
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint want_v, input longint got_v);
    fail_count_o++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (score_mirror[k]) score_mirror[k] = '0;
      owed_results.delete();
      pending_o = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        seen.read_value      = res_mon.read_value;
        seen.insert_position = res_mon.insert_position;
        seen.inserted        = res_mon.inserted;
        if (owed_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result transaction with nothing owed, actual %0d/%0d/%0d", $time,
                   seen.read_value, seen.insert_position, seen.inserted);
        end else begin
          owed = owed_results.pop_front();
          results_checked_o++;
          if (seen.inserted === 1'b1) scores_placed_o++;
          if (seen.read_value !== owed.read_value)
            report_mismatch("read_value", owed.read_value, seen.read_value);
          if (seen.insert_position !== owed.insert_position)
            report_mismatch("insert_position", owed.insert_position, seen.insert_position);
          if (seen.inserted !== owed.inserted)
            report_mismatch("inserted", owed.inserted, seen.inserted);
        end
      end
      if (req_mon.valid && req_mon.ready)
        owed_results.push_back(apply_action(act_e'(req_mon.action), req_mon.index,
                                            req_mon.value));
      pending_o = owed_results.size();
    end
  end

  initial begin
    fail_count_o      = 0;
    results_checked_o = 0;
    scores_placed_o   = 0;
    pending_o         = 0;
  end

endmodule

@@ verif/sorted_top_n_table_test.sv @@
// ----------------------------------------------------------------------------
// sorted_top_n_table_test
// Drives load, sort, insert and read requests into the score table: a short
// directed set of edge cases, then random leaderboard rounds mixed with
// stray requests, with bursty traffic and result back-pressure. Checking is
// done by score_table_checker.
// ----------------------------------------------------------------------------
module sorted_top_n_table_test;
  import stnt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 1330;
  localparam int TAIL_CYCLES    = 250;

  logic clk_i;
  logic rst_ni;

  stnt_in_if  req_if ();
  stnt_out_if res_if ();

  int fail_count;
  int pending;
  int results_checked;
  int scores_placed;
  int act_count [4];
  int sent;
  int hold_requests;
  int holds_served;
  bit gaps_on;
  int burst_left;
  int quiet_cycles;
  int rx_cycle;
  int rx_mode;
  int stall_left;
  int directed_items;

  sorted_top_n_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  score_table_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_mon           (req_if),
    .res_mon           (res_if),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .results_checked_o (results_checked),
    .scores_placed_o   (scores_placed)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results owed", $time,
                 quiet_cycles, pending);
        $display("** sorted_top_n_table: FAILED **");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    res_if.ready = 1'b0;
    holds_served = 0;
    rx_cycle     = 0;
    rx_mode      = 0;
    stall_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_served < hold_requests) begin
        holds_served++;
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (rx_cycle % 80 == 0) rx_mode = $urandom_range(0, 3);
      rx_cycle++;
      case (rx_mode)
        0: res_if.ready = 1'b1;
        1: res_if.ready = $urandom_range(0, 1);
        2: res_if.ready = ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            res_if.ready = 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left   = $urandom_range(2, 20);
            res_if.ready = 1'b0;
          end else begin
            res_if.ready = 1'b1;
          end
        end
      endcase
    end
  end

  task automatic send_item(input act_e act, input logic [IDX_W-1:0] idx,
                           input logic signed [VAL_W-1:0] val);
    req_if.action = act;
    req_if.index  = idx;
    req_if.value  = val;
    req_if.valid  = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    act_count[int'(act)]++;
    sent++;
    @(negedge clk_i);
  endtask

  task automatic pace();
    if (gaps_on) begin
      if (burst_left == 0) begin
        req_if.valid = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_score(input bit tie_heavy);
    int sel;
    int near_zero;
    sel = $urandom_range(0, 9);
    if (tie_heavy ? (sel < 7) : (sel < 2)) begin
      near_zero = int'($urandom_range(0, 12)) - 6;
      return near_zero;
    end
    if (sel == 9) begin
      case ($urandom_range(0, 4))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic act_e pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return ACT_LOAD;
    if (r < 28) return ACT_SORT;
    if (r < 68) return ACT_INSERT;
    return ACT_READ;
  endfunction

  // fill the table, sort it, then feed it new scores and peek at it
  task automatic leaderboard_round(input bit tie_heavy);
    int i;
    for (i = 0; i < 16; i++) begin
      pace();
      send_item(ACT_LOAD, IDX_W'(i), pick_score(tie_heavy));
    end
    pace();
    send_item(ACT_SORT, IDX_W'($urandom_range(0, 15)), $urandom);
    repeat ($urandom_range(4, 12)) begin
      pace();
      send_item(ACT_INSERT, IDX_W'($urandom_range(0, 15)), pick_score(tie_heavy));
      if ($urandom_range(0, 1) == 1) begin
        pace();
        send_item(ACT_READ, IDX_W'($urandom_range(0, 15)), $urandom);
      end
    end
  endtask

  initial begin
    req_if.valid  = 1'b0;
    req_if.action = ACT_LOAD;
    req_if.index  = '0;
    req_if.value  = '0;
    rst_ni        = 1'b0;
    hold_requests = 0;
    gaps_on       = 1'b0;
    burst_left    = 0;
    sent          = 0;
    quiet_cycles  = 0;
    foreach (act_count[a]) act_count[a] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed edge cases
    send_item(ACT_READ,   4'd0,  32'sh5a5a_5a5a);
    send_item(ACT_READ,   4'd15, 32'sh0);
    send_item(ACT_INSERT, 4'd0,  32'sd0);
    send_item(ACT_INSERT, 4'd9,  -32'sd1);
    send_item(ACT_INSERT, 4'd0,  32'sd1);
    send_item(ACT_LOAD,   4'd0,  32'sh8000_0000);
    send_item(ACT_LOAD,   4'd15, 32'sh7fff_ffff);
    send_item(ACT_LOAD,   4'd7,  -32'sd5);
    send_item(ACT_READ,   4'd0,  32'sh0);
    send_item(ACT_READ,   4'd15, 32'shffff_ffff);
    send_item(ACT_SORT,   4'd15, 32'shffff_ffff);
    send_item(ACT_READ,   4'd0,  32'sh0);
    send_item(ACT_READ,   4'd15, 32'sh0);
    send_item(ACT_INSERT, 4'd0,  32'sh7fff_ffff);
    send_item(ACT_INSERT, 4'd0,  32'sh8000_0000);
    send_item(ACT_LOAD,   4'd3,  32'sd100);
    send_item(ACT_INSERT, 4'd0,  32'sd50);
    send_item(ACT_READ,   4'd2,  32'sh0);
    send_item(ACT_READ,   4'd3,  32'sh0);
    send_item(ACT_INSERT, 4'd0,  32'sh8000_0001);
    send_item(ACT_SORT,   4'd0,  32'sh0);
    send_item(ACT_READ,   4'd1,  32'sh1234_5678);
    send_item(ACT_LOAD,   4'd15, -32'sd1);
    send_item(ACT_READ,   4'd15, 32'sh0);
    directed_items = sent;

    for (int phase = 0; phase < 4; phase++) begin
      gaps_on = (phase != 0);
      if (phase == 1) hold_requests++;
      if (phase == 2) wait_drained();
      while (sent < directed_items + (phase + 1) * RANDOM_ITEMS / 4) begin
        if ($urandom_range(0, 9) < 6) begin
          leaderboard_round(phase[0]);
        end else begin
          repeat (10) begin
            pace();
            send_item(pick_action(), IDX_W'($urandom_range(0, 15)), pick_score(phase[0]));
          end
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Covered %0d transactions: %0d load, %0d sort, %0d insert, %0d read.",
             sent, act_count[ACT_LOAD], act_count[ACT_SORT], act_count[ACT_INSERT],
             act_count[ACT_READ]);
    $display("%0d results checked, %0d scores placed, %0d failures.",
             results_checked, scores_placed, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** sorted_top_n_table: PASSED **");
    end else begin
      $display("** sorted_top_n_table: FAILED **");
    end
    $finish;
  end

endmodule
